### design/clipped_blit_to_argb_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clipped blit
// Shared concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_BLIT_TO_ARGB_MACROS_SVH
`define CLIPPED_BLIT_TO_ARGB_MACROS_SVH

`ifndef SYNTHESIS

`define CBTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clipped blit assertion failed");

`define CBTA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clipped blit assertion failed");

`else

`define CBTA_ASSERT_IMP(lbl, ante, cons)

`define CBTA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### design/cbta_pkg.sv
// ----------------------------------------------------------------------------
// Clipped blit package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package cbta_pkg;

  localparam int unsigned MAX_DIM_DEF      = 4096;
  localparam int unsigned MAX_FB_WORDS_DEF = 16777216;
  localparam int unsigned ADDR_RANGE       = 16777216;

  localparam int DIM_W  = 13;
  localparam int LEN_W  = 3;
  localparam int BYTE_W = 8;
  localparam int FBW_W  = 25;
  localparam int ADDR_W = 24;
  localparam int WORD_W = 32;
  localparam int PROD_W = 2 * DIM_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int POS_W  = DIM_W + 2;

  localparam logic [DIM_W-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [DIM_W-1:0] SCREEN_H_RST = 13'd480;
  localparam logic [FBW_W-1:0] FB_WORDS_RST = 25'd307200;
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_FB_WORDS      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              first;
    logic [DIM_W-1:0]  rect_x;
    logic [DIM_W-1:0]  rect_y;
    logic [DIM_W-1:0]  rect_width;
    logic [DIM_W-1:0]  rect_height;
    logic [LEN_W-1:0]  bytes_per_pixel;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
  } pix_in_t;

  typedef struct packed {
    logic [DIM_W-1:0] screen_w;
    logic [DIM_W-1:0] screen_h;
    logic [FBW_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  x;
    logic [DIM_W-1:0]  y;
    logic [WORD_W-1:0] pixel;
  } s1_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned cap);
    logic [DIM_W-1:0] res;
    res = v;
    if ({19'd0, v} > cap) begin
      res = DIM_W'(cap);
    end
    return res;
  endfunction

endpackage

### design/cbta_clip.sv
// ----------------------------------------------------------------------------
// Clipped blit raster walker
// Latches rectangle geometry, walks row and column counters, clips each pixel
// against the screen and builds the ARGB word into the first pipeline stage.
// ----------------------------------------------------------------------------
module cbta_clip
  import cbta_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  pix_in_t in_item,
  input  cfg_t    cfg,
  input  logic    s1_ready,
  output logic    s1_valid,
  output s1_t     s1_data
);

  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] ox_r, ox_nxt;
  logic [DIM_W-1:0] oy_r, oy_nxt;
  logic [DIM_W-1:0] w_r, w_nxt;
  logic [DIM_W-1:0] h_r, h_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  logic             s1_v_r;
  s1_t              s1_r, s1_nxt;

  logic             accept;
  logic             active;
  logic             on_screen;
  logic [DIM_W-1:0] col_e, row_e, col_inc;
  logic [POS_W-1:0] x_s, y_s;
  logic [BYTE_W-1:0] g_byte, b_byte;

  assign in_ready = !s1_v_r || s1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ox_nxt  = ox_r;
    oy_nxt  = oy_r;
    w_nxt   = w_r;
    h_nxt   = h_r;
    len_nxt = len_r;
    col_e   = col_r;
    row_e   = row_r;
    if (in_item.first) begin
      ox_nxt  = in_item.rect_x;
      oy_nxt  = in_item.rect_y;
      w_nxt   = clamp_dim(in_item.rect_width, MAX_DIM);
      h_nxt   = clamp_dim(in_item.rect_height, MAX_DIM);
      len_nxt = in_item.bytes_per_pixel;
      col_e   = '0;
      row_e   = '0;
    end

    active  = (w_nxt != '0) && (row_e < h_nxt);
    col_inc = col_e + DIM_W'(1);
    col_nxt = col_e;
    row_nxt = row_e;
    if (active) begin
      if (col_inc >= w_nxt) begin
        col_nxt = '0;
        row_nxt = row_e + DIM_W'(1);
      end else begin
        col_nxt = col_inc;
      end
    end

    x_s = {{2{ox_nxt[DIM_W-1]}}, ox_nxt} + {2'b00, col_e};
    y_s = {{2{oy_nxt[DIM_W-1]}}, oy_nxt} + {2'b00, row_e};
    on_screen = active && !x_s[POS_W-1] && !y_s[POS_W-1] &&
                (x_s[POS_W-2:0] < {1'b0, cfg.screen_w}) &&
                (y_s[POS_W-2:0] < {1'b0, cfg.screen_h});

    g_byte = (len_nxt > LEN_W'(1)) ? in_item.byte1 : in_item.byte0;
    b_byte = (len_nxt > LEN_W'(2)) ? in_item.byte2 : in_item.byte0;

    s1_nxt.x     = x_s[DIM_W-1:0];
    s1_nxt.y     = y_s[DIM_W-1:0];
    s1_nxt.pixel = {ALPHA_OPAQUE, in_item.byte0, g_byte, b_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
      w_r    <= '0;
      h_r    <= '0;
      len_r  <= LEN_W'(1);
      s1_v_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        ox_r  <= ox_nxt;
        oy_r  <= oy_nxt;
        w_r   <= w_nxt;
        h_r   <= h_nxt;
        len_r <= len_nxt;
      end
      if (in_ready) begin
        s1_v_r <= accept && on_screen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_data  = s1_r;

endmodule

### design/cbta_addr.sv
// ----------------------------------------------------------------------------
// Clipped blit address stage
// Multiplies the row by the pitch, adds the column, checks the framebuffer
// limit and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module cbta_addr
  import cbta_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  output logic              s1_ready,
  input  s1_t               s1_data,
  input  cfg_t              cfg,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_address,
  output logic [WORD_W-1:0] out_pixel
);

  logic              s2_v_r;
  logic [PROD_W-1:0] prod_r;
  logic [DIM_W-1:0]  x_r;
  logic [WORD_W-1:0] pix_r;

  logic              out_v_r;
  logic [ADDR_W-1:0] addr_r;
  logic [WORD_W-1:0] opix_r;

  logic              out_adv;
  logic              s2_adv;
  logic [SUM_W-1:0]  addr_sum;
  logic              in_range;

  assign out_adv  = !out_v_r || out_ready;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_ready = s2_adv;

  assign addr_sum = {1'b0, prod_r} + {{(SUM_W-DIM_W){1'b0}}, x_r};
  assign in_range = addr_sum < {{(SUM_W-FBW_W){1'b0}}, cfg.limit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_adv) begin
        s2_v_r <= s1_valid;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r && in_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      prod_r <= s1_data.y * cfg.screen_w;
      x_r    <= s1_data.x;
      pix_r  <= s1_data.pixel;
    end
    if (out_adv && s2_v_r) begin
      addr_r <= addr_sum[ADDR_W-1:0];
      opix_r <= pix_r;
    end
  end

  assign out_valid   = out_v_r;
  assign out_address = addr_r;
  assign out_pixel   = opix_r;

endmodule

### design/clipped_blit_to_argb.sv
// ----------------------------------------------------------------------------
// Clipped rectangle blit to ARGB8888
// Walks a rectangle of source pixels, clips it to the screen and framebuffer
// and emits word addresses with opaque ARGB8888 pixel words.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in_       slave      in_tvalid/in_tready  tdata geometry and bytes, tuser first
// out_      master     out_tvalid/out_tready tdata address and pixel word
// cfg_      write      cfg_we               cfg_index, cfg_wdata
//
// One word is accepted per cycle when the clip register can take it; kept
// pixels pass the clip register, the row times pitch multiply and the address add
// and compare. Back pressure moves stage by stage, and empty stages are filled
// while the output waits. Reset is synchronous and active low: it clears the
// counters, the latched geometry and the stage valids and loads the defaults.
// ----------------------------------------------------------------------------
`include "clipped_blit_to_argb_macros.svh"

module clipped_blit_to_argb
  import cbta_pkg::*;
#(
  parameter int unsigned MAX_DIM      = MAX_DIM_DEF,
  parameter int unsigned MAX_FB_WORDS = MAX_FB_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // rect_x, rect_y, rect_width, rect_height, bytes_per_pixel, byte0, byte1, byte2
  input  logic [79:0] in_tdata,
  // first
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // write_address, pixel_word
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [FBW_W-1:0] cfg_wdata
);

  localparam int unsigned LIMIT_CAP =
    (MAX_FB_WORDS < ADDR_RANGE) ? MAX_FB_WORDS : ADDR_RANGE;

  logic [DIM_W-1:0] sw_r;
  logic [DIM_W-1:0] sh_r;
  logic [FBW_W-1:0] limit_r;
  logic [FBW_W-1:0] limit_nxt;

  cfg_t              cfg;
  pix_in_t           in_item;
  logic              s1_valid;
  logic              s1_ready;
  s1_t               s1_data;
  logic [ADDR_W-1:0] out_address;
  logic [WORD_W-1:0] out_pixel;

  assign limit_nxt = ({7'd0, cfg_wdata} > LIMIT_CAP) ? FBW_W'(LIMIT_CAP) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r    <= clamp_dim(SCREEN_W_RST, MAX_DIM);
      sh_r    <= clamp_dim(SCREEN_H_RST, MAX_DIM);
      limit_r <= ({7'd0, FB_WORDS_RST} > LIMIT_CAP) ? FBW_W'(LIMIT_CAP) : FB_WORDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  sw_r    <= clamp_dim(cfg_wdata[DIM_W-1:0], MAX_DIM);
        REG_SCREEN_HEIGHT: sh_r    <= clamp_dim(cfg_wdata[DIM_W-1:0], MAX_DIM);
        REG_FB_WORDS:      limit_r <= limit_nxt;
        default: begin
        end
      endcase
    end
  end

  assign cfg.screen_w = sw_r;
  assign cfg.screen_h = sh_r;
  assign cfg.limit    = limit_r;

  assign in_item.first           = in_tuser[0];
  assign in_item.rect_x          = in_tdata[12:0];
  assign in_item.rect_y          = in_tdata[25:13];
  assign in_item.rect_width      = in_tdata[38:26];
  assign in_item.rect_height     = in_tdata[51:39];
  assign in_item.bytes_per_pixel = in_tdata[54:52];
  assign in_item.byte0           = in_tdata[62:55];
  assign in_item.byte1           = in_tdata[70:63];
  assign in_item.byte2           = in_tdata[78:71];

  cbta_clip #(
    .MAX_DIM (MAX_DIM)
  ) u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .cfg      (cfg),
    .s1_ready (s1_ready),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  cbta_addr u_addr (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_data     (s1_data),
    .cfg         (cfg),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_address (out_address),
    .out_pixel   (out_pixel)
  );

  assign out_tdata = {out_pixel, out_address};

  `CBTA_ASSERT_IMP(a_ready_when_empty, !s1_valid, in_tready)
  `CBTA_ASSERT_IMP(a_alpha_opaque, out_tvalid, out_tdata[55:48] == ALPHA_OPAQUE)
  `CBTA_ASSERT_IMP(a_empty_after_reset, $past(!rst_n), in_tready && !out_tvalid && !s1_valid)
  `CBTA_ASSERT_NXT(a_no_result_from_idle, !s1_valid && !out_tvalid && !in_tvalid,
                   !out_tvalid || $past(s1_ready))

endmodule
